// ----- rtl/core/dsna_pkg.sv -----
// dsna_pkg: shared constants and types for the dragonfly spread node allocator
// used by dsna_map_ram, dsna_cursor and dragonfly_spread_node_allocator
package dsna_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int MAX_REQUEST = 64;
  localparam int ADDR_W      = $clog2(MAX_NODES);
  localparam int CNT_W       = $clog2(MAX_NODES + 1);
  localparam int CFG_W       = 7;
  localparam int REQ_W       = 7;
  localparam int PROD1_W     = 2 * CFG_W;
  localparam int PROD2_W     = 3 * CFG_W;

  // configuration register indexes
  localparam logic [1:0] REG_NODES_PER_ROUTER  = 2'd0;
  localparam logic [1:0] REG_ROUTERS_PER_GROUP = 2'd1;
  localparam logic [1:0] REG_GROUP_COUNT       = 2'd2;

  // action codes
  localparam logic [1:0] ACT_MARK_FREE = 2'd0;
  localparam logic [1:0] ACT_MARK_BUSY = 2'd1;
  localparam logic [1:0] ACT_ALLOC     = 2'd2;

  typedef struct packed {
    logic [CFG_W-1:0]  npr;
    logic [CFG_W-1:0]  rpg;
    logic [CFG_W-1:0]  gc;
    logic [CNT_W-1:0]  stride;  // nodes in one group
  } geom_t;

  typedef struct packed {
    logic load;
    logic step;
  } cur_ctl_t;

endpackage

// ----- rtl/core/dsna_map_ram.sv -----
// dsna_map_ram: one-bit free map, one write port, one registered read port
// depends on dsna_pkg for depth and address width
module dsna_map_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [dsna_pkg::ADDR_W-1:0] waddr,
  input  logic                       wdata,
  input  logic [dsna_pkg::ADDR_W-1:0] raddr,
  output logic                       rdata
);

  logic mem [dsna_pkg::MAX_NODES];
  logic rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/dsna_cursor.sv -----
// dsna_cursor: steps a node id through spread order without division
// depends on dsna_pkg for geometry and control structs
module dsna_cursor (
  input  logic                        clk,
  input  dsna_pkg::geom_t             geom,
  input  dsna_pkg::cur_ctl_t          ctl,
  output logic [dsna_pkg::ADDR_W-1:0] id
);

  localparam int W = dsna_pkg::CFG_W;
  localparam int A = dsna_pkg::ADDR_W;

  logic [W-1:0] a_r, a_nxt;     // node within router
  logic [W-1:0] b_r, b_nxt;     // router within group
  logic [W-1:0] g_r, g_nxt;     // group
  logic [A-1:0] id_r, id_nxt;
  logic [A-1:0] base_r, base_nxt; // first node of router b in group 0
  logic [A+1:0] jump;

  // same router in the next group: back to the router's first node, add a group
  assign jump = (A+2)'(id_r) + (A+2)'(1) + (A+2)'(geom.stride) - (A+2)'(geom.npr);

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    g_nxt    = g_r;
    id_nxt   = id_r;
    base_nxt = base_r;
    if (ctl.load) begin
      a_nxt    = '0;
      b_nxt    = '0;
      g_nxt    = '0;
      id_nxt   = '0;
      base_nxt = '0;
    end else if (ctl.step) begin
      if (a_r + W'(1) != geom.npr) begin
        a_nxt  = a_r + W'(1);
        id_nxt = id_r + A'(1);
      end else begin
        a_nxt = '0;
        if (g_r + W'(1) != geom.gc) begin
          g_nxt  = g_r + W'(1);
          id_nxt = jump[A-1:0];
        end else begin
          g_nxt = '0;
          if (b_r + W'(1) != geom.rpg) begin
            b_nxt    = b_r + W'(1);
            base_nxt = base_r + A'(geom.npr);
            id_nxt   = base_r + A'(geom.npr);
          end else begin
            b_nxt    = '0;
            base_nxt = '0;
            id_nxt   = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    g_r    <= g_nxt;
    id_r   <= id_nxt;
    base_r <= base_nxt;
  end

  assign id = id_r;

endmodule

// ----- rtl/core/dragonfly_spread_node_allocator.sv -----
// dragonfly_spread_node_allocator: free map, free count and allocation sequencer
// depends on dsna_pkg, dsna_map_ram and dsna_cursor
// sequence: a mark item reads the node's free bit, then writes it if it changes; allocate
//   runs MUL1, MUL2, CHECK to a refusal or empty grant, else a count pass and a walk over the machine nodes
// throughput: one item at a time, set by the single free map read port
// reset: clearing pass over all 1024 free map entries with busy high; config to 4/16/16
// results appear on out_valid for one cycle each; the receiver cannot stall
module dragonfly_spread_node_allocator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_action,
  input  logic [dsna_pkg::ADDR_W-1:0]       in_node,
  input  logic [dsna_pkg::REQ_W-1:0]        in_count,
  output logic                              out_valid,
  output logic [dsna_pkg::ADDR_W-1:0]       out_node_id,
  output logic                              out_granted,
  output logic                              out_last,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [dsna_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int A  = dsna_pkg::ADDR_W;
  localparam int C  = dsna_pkg::CNT_W;
  localparam int W  = dsna_pkg::CFG_W;
  localparam int R  = dsna_pkg::REQ_W;
  localparam int P1 = dsna_pkg::PROD1_W;
  localparam int P2 = dsna_pkg::PROD2_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MARK  = 3'd2;
  localparam logic [2:0] S_MUL1  = 3'd3;
  localparam logic [2:0] S_MUL2  = 3'd4;
  localparam logic [2:0] S_CHECK = 3'd5;
  localparam logic [2:0] S_COUNT = 3'd6;
  localparam logic [2:0] S_WALK  = 3'd7;

  logic [2:0]   state_r, state_nxt;
  logic [A-1:0] clr_r, clr_nxt;
  logic [1:0]   act_r, act_nxt;
  logic [A-1:0] node_r, node_nxt;
  logic [R-1:0] cnt_r, cnt_nxt;
  logic [C-1:0] free_total_r, free_total_nxt;
  logic [P1-1:0] prod_r, prod_nxt;
  logic [P2-1:0] total_r, total_nxt;
  logic [C-1:0] iss_r, iss_nxt;
  logic [C-1:0] acc_r, acc_nxt;
  logic [R-1:0] k_r, k_nxt;
  logic         rd_vld_r, rd_vld_nxt;
  logic [A-1:0] rd_id_r, rd_id_nxt;
  logic [W-1:0] npr_r, rpg_r, gc_r;

  logic         out_valid_r, out_valid_nxt;
  logic [A-1:0] out_node_id_r, out_node_id_nxt;
  logic         out_granted_r, out_granted_nxt;
  logic         out_last_r, out_last_nxt;

  logic         ram_we;
  logic [A-1:0] ram_waddr;
  logic         ram_wdata;
  logic [A-1:0] ram_raddr;
  logic         ram_rdata;

  dsna_pkg::geom_t    geom;
  dsna_pkg::cur_ctl_t cur_ctl;
  logic [A-1:0]       cur_id;

  logic         want;
  logic         issuing;
  logic [C-1:0] tot;

  assign tot  = total_r[C-1:0];
  assign want = (act_r == dsna_pkg::ACT_MARK_FREE);

  assign geom.npr    = npr_r;
  assign geom.rpg    = rpg_r;
  assign geom.gc     = gc_r;
  assign geom.stride = prod_r[C-1:0];

  dsna_map_ram u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dsna_cursor u_cursor (
    .clk  (clk),
    .geom (geom),
    .ctl  (cur_ctl),
    .id   (cur_id)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      npr_r <= W'(4);
      rpg_r <= W'(16);
      gc_r  <= W'(16);
    end else if (cfg_we) begin
      case (cfg_index)
        dsna_pkg::REG_NODES_PER_ROUTER:  npr_r <= cfg_wdata;
        dsna_pkg::REG_ROUTERS_PER_GROUP: rpg_r <= cfg_wdata;
        dsna_pkg::REG_GROUP_COUNT:       gc_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    act_nxt         = act_r;
    node_nxt        = node_r;
    cnt_nxt         = cnt_r;
    free_total_nxt  = free_total_r;
    prod_nxt        = prod_r;
    total_nxt       = total_r;
    iss_nxt         = iss_r;
    acc_nxt         = acc_r;
    k_nxt           = k_r;
    rd_vld_nxt      = 1'b0;
    rd_id_nxt       = rd_id_r;
    out_valid_nxt   = 1'b0;
    out_node_id_nxt = '0;
    out_granted_nxt = 1'b0;
    out_last_nxt    = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = node_r;
    ram_wdata       = 1'b0;
    ram_raddr       = in_node;
    cur_ctl.load    = 1'b0;
    cur_ctl.step    = 1'b0;
    issuing         = 1'b0;

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = 1'b0;
        clr_nxt   = clr_r + A'(1);
        if (clr_r == A'(dsna_pkg::MAX_NODES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          act_nxt  = in_action;
          node_nxt = in_node;
          cnt_nxt  = in_count;
          if (in_action == dsna_pkg::ACT_MARK_FREE || in_action == dsna_pkg::ACT_MARK_BUSY) begin
            state_nxt = S_MARK;
          end else if (in_action == dsna_pkg::ACT_ALLOC) begin
            state_nxt = S_MUL1;
          end
        end
      end
      S_MARK: begin
        if (ram_rdata != want) begin
          ram_we    = 1'b1;
          ram_waddr = node_r;
          ram_wdata = want;
          free_total_nxt = want ? free_total_r + C'(1) : free_total_r - C'(1);
        end
        state_nxt = S_IDLE;
      end
      S_MUL1: begin
        prod_nxt  = P1'(npr_r) * P1'(rpg_r);
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        total_nxt = P2'(prod_r) * P2'(gc_r);
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        out_valid_nxt = 1'b1;
        out_last_nxt  = 1'b1;
        state_nxt     = S_IDLE;
        if (npr_r == '0 || rpg_r == '0 || gc_r == '0
            || total_r > P2'(dsna_pkg::MAX_NODES) || cnt_r > R'(dsna_pkg::MAX_REQUEST)) begin
          out_granted_nxt = 1'b0;
        end else if (cnt_r == '0) begin
          out_granted_nxt = 1'b1;
        end else if (free_total_r < C'(cnt_r)) begin
          out_granted_nxt = 1'b0;
        end else begin
          // free count is enough over the whole store; recount inside the machine
          out_valid_nxt = 1'b0;
          out_last_nxt  = 1'b0;
          iss_nxt       = '0;
          acc_nxt       = '0;
          state_nxt     = S_COUNT;
        end
      end
      S_COUNT: begin
        ram_raddr = iss_r[A-1:0];
        issuing   = (iss_r < tot);
        if (issuing) begin
          iss_nxt = iss_r + C'(1);
        end
        rd_vld_nxt = issuing;
        if (rd_vld_r && ram_rdata) begin
          acc_nxt = acc_r + C'(1);
        end
        if (!issuing && !rd_vld_r) begin
          if (acc_r < C'(cnt_r)) begin
            out_valid_nxt = 1'b1;
            out_last_nxt  = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            cur_ctl.load = 1'b1;
            iss_nxt      = '0;
            k_nxt        = '0;
            state_nxt    = S_WALK;
          end
        end
      end
      S_WALK: begin
        ram_raddr = cur_id;
        issuing   = (iss_r < tot);
        if (issuing) begin
          iss_nxt      = iss_r + C'(1);
          cur_ctl.step = 1'b1;
        end
        rd_vld_nxt = issuing;
        rd_id_nxt  = cur_id;
        if (rd_vld_r && ram_rdata) begin
          out_valid_nxt   = 1'b1;
          out_node_id_nxt = rd_id_r;
          out_granted_nxt = 1'b1;
          k_nxt           = k_r + R'(1);
          if (k_r + R'(1) == cnt_r) begin
            out_last_nxt = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else if (!issuing && !rd_vld_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      free_total_r <= '0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      free_total_r <= free_total_nxt;
      rd_vld_r     <= rd_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r         <= act_nxt;
    node_r        <= node_nxt;
    cnt_r         <= cnt_nxt;
    prod_r        <= prod_nxt;
    total_r       <= total_nxt;
    iss_r         <= iss_nxt;
    acc_r         <= acc_nxt;
    k_r           <= k_nxt;
    rd_id_r       <= rd_id_nxt;
    out_node_id_r <= out_node_id_nxt;
    out_granted_r <= out_granted_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign busy        = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_node_id = out_node_id_r;
  assign out_granted = out_granted_r;
  assign out_last    = out_last_r;

endmodule

// ----- sim/dsna_alloc_checker.sv -----
// dsna_alloc_checker: predicts the grant beats of the dragonfly spread node
// allocator and compares them with out_*; depends on dsna_pkg only
`timescale 1ns / 100ps

module dsna_alloc_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [1:0]                    in_action,
  input  logic [dsna_pkg::ADDR_W-1:0]   in_node,
  input  logic [dsna_pkg::REQ_W-1:0]    in_count,
  input  logic                          out_valid,
  input  logic [dsna_pkg::ADDR_W-1:0]   out_node_id,
  input  logic                          out_granted,
  input  logic                          out_last,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [dsna_pkg::CFG_W-1:0]    cfg_wdata,
  output int                            fail_count,
  output int                            pending
);

  typedef struct {
    logic [dsna_pkg::ADDR_W-1:0] node_id;
    logic                        granted;
    logic                        last;
  } alloc_beat_t;

  alloc_beat_t pending_grants[$];

  bit          node_free [dsna_pkg::MAX_NODES];
  int unsigned free_nodes;
  int unsigned npr;
  int unsigned rpg;
  int unsigned gc;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t ns  %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  function automatic void push_beat(input int unsigned id, input bit ok, input bit fin);
    alloc_beat_t b;
    b.node_id = id[dsna_pkg::ADDR_W-1:0];
    b.granted = ok;
    b.last    = fin;
    pending_grants.push_back(b);
  endfunction

  function automatic void apply_request(input logic [1:0] act,
                                        input logic [dsna_pkg::ADDR_W-1:0] nd,
                                        input logic [dsna_pkg::REQ_W-1:0] cnt);
    int unsigned total;
    int unsigned avail;
    int unsigned cursor;
    int unsigned rt;
    int unsigned k;
    bit          want;
    case (act)
      dsna_pkg::ACT_MARK_FREE, dsna_pkg::ACT_MARK_BUSY: begin
        want = (act == dsna_pkg::ACT_MARK_FREE);
        if (node_free[nd] != want) begin
          node_free[nd] = want;
          if (want) free_nodes++;
          else free_nodes--;
        end
      end
      dsna_pkg::ACT_ALLOC: begin
        if (npr == 0 || rpg == 0 || gc == 0) begin
          push_beat(0, 1'b0, 1'b1);
        end else begin
          total = npr * rpg * gc;
          if (total > dsna_pkg::MAX_NODES || cnt > dsna_pkg::MAX_REQUEST) begin
            push_beat(0, 1'b0, 1'b1);
          end else if (cnt == 0) begin
            push_beat(0, 1'b1, 1'b1);
          end else begin
            // only nodes inside the configured machine are available
            avail = 0;
            if (free_nodes >= cnt)
              for (int unsigned i = 0; i < total; i++) avail += node_free[i];
            if (avail < cnt) begin
              push_beat(0, 1'b0, 1'b1);
            end else begin
              cursor = 0;
              k = 0;
              for (int unsigned i = 0; i < total && k < cnt; i++) begin
                if (cursor < total && node_free[cursor]) begin
                  push_beat(cursor, 1'b1, k + 1 == cnt);
                  k++;
                end
                // spread order: along the router, then same router of next group, then next router
                if ((cursor + 1) % npr != 0) begin
                  cursor = cursor + 1;
                end else begin
                  rt = cursor / npr;
                  if (rt / rpg != gc - 1) rt = rt + rpg;
                  else rt = (rt + 1) % rpg;
                  cursor = rt * npr;
                end
                cursor = cursor % dsna_pkg::MAX_NODES;
              end
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    alloc_beat_t want;
    if (!rst_n) begin
      foreach (node_free[i]) node_free[i] = 1'b0;
      free_nodes = 0;
      npr = 4;
      rpg = 16;
      gc  = 16;
      pending_grants.delete();
    end else begin
      if (out_valid) begin
        if (pending_grants.size() == 0) begin
          report_mismatch("beat with nothing pending, node_id", out_node_id, 0);
        end else begin
          want = pending_grants.pop_front();
          if (out_node_id !== want.node_id)
            report_mismatch("node_id", out_node_id, want.node_id);
          if (out_granted !== want.granted)
            report_mismatch("granted", out_granted, want.granted);
          if (out_last !== want.last)
            report_mismatch("last", out_last, want.last);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          dsna_pkg::REG_NODES_PER_ROUTER:  npr = cfg_wdata;
          dsna_pkg::REG_ROUTERS_PER_GROUP: rpg = cfg_wdata;
          dsna_pkg::REG_GROUP_COUNT:       gc  = cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy) apply_request(in_action, in_node, in_count);
    end
    pending = pending_grants.size();
  end

endmodule

// ----- sim/tb_dragonfly_spread_node_allocator.sv -----
// tb_dragonfly_spread_node_allocator: drives marks, allocations and geometry
// writes into the allocator; dsna_alloc_checker predicts and compares the beats
`timescale 1ns / 100ps

module tb_dragonfly_spread_node_allocator;

  localparam logic [1:0] ACT_UNUSED     = 2'd3;
  localparam int         N_PHASES       = 11;
  localparam int         SETTLE_CYCLES  = 8;
  localparam int         WATCHDOG_LIMIT = 20000;

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic [1:0]                    in_action;
  logic [dsna_pkg::ADDR_W-1:0]   in_node;
  logic [dsna_pkg::REQ_W-1:0]    in_count;
  logic                          out_valid;
  logic [dsna_pkg::ADDR_W-1:0]   out_node_id;
  logic                          out_granted;
  logic                          out_last;
  logic                          cfg_we;
  logic [1:0]                    cfg_index;
  logic [dsna_pkg::CFG_W-1:0]    cfg_wdata;
  int                            fail_count;
  int                            pending;
  bit                            no_gaps;
  int                            idle_cycles;

  // geometry per random phase: nodes per router, routers per group, groups
  int unsigned phase_npr   [N_PHASES] = '{4, 1, 2, 64, 0, 3, 1, 64, 127, 5, 1};
  int unsigned phase_rpg   [N_PHASES] = '{16, 1, 8, 64, 16, 5, 1, 4, 1, 3, 64};
  int unsigned phase_gc    [N_PHASES] = '{16, 1, 4, 64, 16, 7, 64, 4, 1, 2, 16};
  int unsigned phase_items [N_PHASES] = '{60, 30, 70, 15, 10, 60, 40, 40, 30, 40, 40};

  dragonfly_spread_node_allocator i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_action   (in_action),
    .in_node     (in_node),
    .in_count    (in_count),
    .out_valid   (out_valid),
    .out_node_id (out_node_id),
    .out_granted (out_granted),
    .out_last    (out_last),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  dsna_alloc_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_action   (in_action),
    .in_node     (in_node),
    .in_count    (in_count),
    .out_valid   (out_valid),
    .out_node_id (out_node_id),
    .out_granted (out_granted),
    .out_last    (out_last),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_item(input logic [1:0] act, input int unsigned nd,
                           input int unsigned cnt);
    start     <= 1'b1;
    in_action <= act;
    in_node   <= dsna_pkg::ADDR_W'(nd);
    in_count  <= dsna_pkg::REQ_W'(cnt);
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (!no_gaps && $urandom_range(0, 99) < 24) begin
      start <= 1'b0;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(5, 40)) @(negedge clk);
      else repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  // hold off until every pending beat is out and the block has gone quiet
  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic set_geometry(input int unsigned npr, input int unsigned rpg,
                              input int unsigned gc);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= dsna_pkg::REG_NODES_PER_ROUTER;
    cfg_wdata <= dsna_pkg::CFG_W'(npr);
    @(negedge clk);
    cfg_index <= dsna_pkg::REG_ROUTERS_PER_GROUP;
    cfg_wdata <= dsna_pkg::CFG_W'(rpg);
    @(negedge clk);
    cfg_index <= dsna_pkg::REG_GROUP_COUNT;
    cfg_wdata <= dsna_pkg::CFG_W'(gc);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // quiet-cycle watchdog: a beat in either direction restarts it
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("dragonfly_spread_node_allocator: mismatch");
    $finish;
  end

  initial begin
    int unsigned item_no;
    int unsigned total;
    int unsigned span;
    int unsigned cap;
    int unsigned pick;
    int unsigned nd;
    int unsigned cnt;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_action = dsna_pkg::ACT_MARK_FREE;
    in_node   = '0;
    in_count  = '0;
    cfg_we    = 1'b0;
    cfg_index = dsna_pkg::REG_NODES_PER_ROUTER;
    cfg_wdata = '0;
    no_gaps   = 1'b0;
    item_no   = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed part on the reset geometry, 1024 nodes, all busy
    send_item(dsna_pkg::ACT_ALLOC, 0, 1);
    send_item(dsna_pkg::ACT_ALLOC, 0, 0);
    send_item(dsna_pkg::ACT_ALLOC, 1023, 127);
    send_item(ACT_UNUSED, 1023, 127);
    send_item(dsna_pkg::ACT_MARK_FREE, 0, 0);
    send_item(dsna_pkg::ACT_MARK_FREE, 0, 0);
    send_item(dsna_pkg::ACT_MARK_FREE, 1023, 0);
    send_item(dsna_pkg::ACT_MARK_FREE, 5, 0);
    send_item(dsna_pkg::ACT_MARK_BUSY, 5, 0);
    send_item(dsna_pkg::ACT_MARK_BUSY, 5, 0);
    send_item(dsna_pkg::ACT_MARK_FREE, 4, 0);
    send_item(dsna_pkg::ACT_MARK_FREE, 64, 0);
    send_item(dsna_pkg::ACT_MARK_FREE, 1, 0);
    send_item(dsna_pkg::ACT_ALLOC, 0, 1);
    // full walk: 0, 1, next group, back to router 1, last node of the machine
    send_item(dsna_pkg::ACT_ALLOC, 0, 5);
    send_item(dsna_pkg::ACT_ALLOC, 0, 6);
    send_item(dsna_pkg::ACT_ALLOC, 0, 65);
    // two-node machine: free nodes above the total do not count
    set_geometry(1, 1, 2);
    send_item(dsna_pkg::ACT_ALLOC, 0, 3);
    send_item(dsna_pkg::ACT_ALLOC, 0, 2);
    set_geometry(0, 1, 1);
    send_item(dsna_pkg::ACT_ALLOC, 0, 0);
    set_geometry(64, 64, 64);
    send_item(dsna_pkg::ACT_ALLOC, 0, 0);
    send_item(dsna_pkg::ACT_ALLOC, 0, 1);

    for (int p = 0; p < N_PHASES; p++) begin
      set_geometry(phase_npr[p], phase_rpg[p], phase_gc[p]);
      total = phase_npr[p] * phase_rpg[p] * phase_gc[p];
      span  = (total == 0 || total > dsna_pkg::MAX_NODES) ? dsna_pkg::MAX_NODES : total;
      cap   = (span < dsna_pkg::MAX_REQUEST) ? span : dsna_pkg::MAX_REQUEST;
      for (int n = 0; n < phase_items[p]; n++) begin
        no_gaps = (item_no >= 150 && item_no < 260);
        pick = $urandom_range(0, 99);
        nd   = ($urandom_range(0, 99) < 85) ? $urandom_range(0, span - 1)
                                            : $urandom_range(0, dsna_pkg::MAX_NODES - 1);
        cnt  = $urandom_range(0, 99);
        if (cnt < 55)      cnt = $urandom_range(1, (cap < 4) ? cap : 4);
        else if (cnt < 75) cnt = $urandom_range(1, cap);
        else if (cnt < 85) cnt = 0;
        else if (cnt < 92) cnt = cap;
        else               cnt = $urandom_range(dsna_pkg::MAX_REQUEST + 1, 127);
        if (pick < 45)      send_item(dsna_pkg::ACT_MARK_FREE, nd, $urandom_range(0, 127));
        else if (pick < 65) send_item(dsna_pkg::ACT_MARK_BUSY, nd, $urandom_range(0, 127));
        else if (pick < 95) send_item(dsna_pkg::ACT_ALLOC, nd, cnt);
        else                send_item(ACT_UNUSED, nd, cnt);
        item_no++;
      end
    end

    no_gaps = 1'b0;
    drain();
    repeat (64) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("dragonfly_spread_node_allocator: match");
    else
      $display("dragonfly_spread_node_allocator: mismatch");
    $finish;
  end

endmodule
